// ===== src/audio_error_concealment_core_assert.svh =====
// Assertion macros shared by the checkers of the concealment core.
// No dependencies; include by bare file name.
`ifndef AUDIO_ERROR_CONCEALMENT_CORE_ASSERT_SVH
`define AUDIO_ERROR_CONCEALMENT_CORE_ASSERT_SVH

// cons must hold at every edge where ante holds
`define AEC_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication check failed");

// cons must hold at the edge after the one where ante holds
`define AEC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

// expr must never hold
`define AEC_ASSERT_NEVER(label, clk, rst_n, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("forbidden condition seen");

`endif

// ===== src/aec_pkg.sv =====
// Shared types and constants of the audio error concealment core.
// No dependencies.
package aec_pkg;

  localparam int SAMPLE_BITS_DEF = 16;
  localparam int COUNT_BITS_DEF  = 32;

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_FLUSH  = 1'b1;

  typedef enum logic [1:0] {
    CLS_PASS,
    CLS_CONCEAL,
    CLS_SILENCE
  } mono_class_e;

  typedef struct packed {
    logic        en;
    mono_class_e left_cls;
    mono_class_e right_cls;
  } aec_tally_t;

endpackage

// ===== src/aec_if.sv =====
// Valid/ready channel interfaces for input and result items.
// No dependencies.
interface aec_in_if #(parameter int SAMPLE_BITS = 16);
  logic                          valid;
  logic                          ready;
  logic                          operation;
  logic signed [SAMPLE_BITS-1:0] left_sample;
  logic                          left_bad;
  logic signed [SAMPLE_BITS-1:0] right_sample;
  logic                          right_bad;

  modport source (output valid, operation, left_sample, left_bad, right_sample, right_bad,
                  input ready);
  modport sink (input valid, operation, left_sample, left_bad, right_sample, right_bad,
                output ready);
endinterface

interface aec_out_if #(parameter int SAMPLE_BITS = 16, parameter int COUNT_BITS = 32);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] left_out;
  logic                          left_still_bad;
  logic                          left_concealed;
  logic signed [SAMPLE_BITS-1:0] right_out;
  logic                          right_still_bad;
  logic                          right_concealed;
  logic [COUNT_BITS-1:0]         valid_total;
  logic [COUNT_BITS-1:0]         concealed_total;
  logic [COUNT_BITS-1:0]         silenced_total;

  modport source (output valid, left_out, left_still_bad, left_concealed, right_out,
                  right_still_bad, right_concealed, valid_total, concealed_total,
                  silenced_total, input ready);
  modport sink (input valid, left_out, left_still_bad, left_concealed, right_out,
                right_still_bad, right_concealed, valid_total, concealed_total,
                silenced_total, output ready);
endinterface

// ===== src/aec_mono_decide.sv =====
// Per-channel decision: pass, neighbor average, or silence.
// Depends on aec_pkg.
module aec_mono_decide import aec_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic signed [SAMPLE_BITS-1:0] pre_val_i,
  input  logic                          pre_bad_i,
  input  logic signed [SAMPLE_BITS-1:0] cur_val_i,
  input  logic                          cur_bad_i,
  input  logic signed [SAMPLE_BITS-1:0] fol_val_i,
  input  logic                          fol_bad_i,
  output logic signed [SAMPLE_BITS-1:0] val_o,
  output mono_class_e                   cls_o
);

  logic signed [SAMPLE_BITS:0] sum;
  logic signed [SAMPLE_BITS:0] sum_adj;

  // round toward zero: bump odd negative sums before the shift
  assign sum     = {pre_val_i[SAMPLE_BITS-1], pre_val_i} + {fol_val_i[SAMPLE_BITS-1], fol_val_i};
  assign sum_adj = sum + {{SAMPLE_BITS{1'b0}}, sum[SAMPLE_BITS] & sum[0]};

  always_comb begin
    if (!cur_bad_i) begin
      val_o = cur_val_i;
      cls_o = CLS_PASS;
    end else if (!pre_bad_i && !fol_bad_i) begin
      val_o = sum_adj[SAMPLE_BITS:1];
      cls_o = CLS_CONCEAL;
    end else begin
      val_o = '0;
      cls_o = CLS_SILENCE;
    end
  end

endmodule

// ===== src/aec_counters.sv =====
// Running totals of passed, concealed and silenced mono samples.
// Depends on aec_pkg.
module aec_counters import aec_pkg::*; #(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  aec_tally_t            tally_i,
  output logic [COUNT_BITS-1:0] valid_cnt_o,
  output logic [COUNT_BITS-1:0] conceal_cnt_o,
  output logic [COUNT_BITS-1:0] silence_cnt_o
);

  logic [COUNT_BITS-1:0] valid_cnt_q, valid_cnt_d;
  logic [COUNT_BITS-1:0] conceal_cnt_q, conceal_cnt_d;
  logic [COUNT_BITS-1:0] silence_cnt_q, silence_cnt_d;
  logic [1:0]            valid_inc, conceal_inc, silence_inc;

  assign valid_inc   = {1'b0, tally_i.left_cls == CLS_PASS}
                     + {1'b0, tally_i.right_cls == CLS_PASS};
  assign conceal_inc = {1'b0, tally_i.left_cls == CLS_CONCEAL}
                     + {1'b0, tally_i.right_cls == CLS_CONCEAL};
  assign silence_inc = {1'b0, tally_i.left_cls == CLS_SILENCE}
                     + {1'b0, tally_i.right_cls == CLS_SILENCE};

  always_comb begin
    valid_cnt_d   = valid_cnt_q;
    conceal_cnt_d = conceal_cnt_q;
    silence_cnt_d = silence_cnt_q;
    if (tally_i.en) begin
      valid_cnt_d   = valid_cnt_q + {{(COUNT_BITS-2){1'b0}}, valid_inc};
      conceal_cnt_d = conceal_cnt_q + {{(COUNT_BITS-2){1'b0}}, conceal_inc};
      silence_cnt_d = silence_cnt_q + {{(COUNT_BITS-2){1'b0}}, silence_inc};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_cnt_q   <= '0;
      conceal_cnt_q <= '0;
      silence_cnt_q <= '0;
    end else begin
      valid_cnt_q   <= valid_cnt_d;
      conceal_cnt_q <= conceal_cnt_d;
      silence_cnt_q <= silence_cnt_d;
    end
  end

  assign valid_cnt_o   = valid_cnt_q;
  assign conceal_cnt_o = conceal_cnt_q;
  assign silence_cnt_o = silence_cnt_q;

endmodule

// ===== src/audio_error_concealment_core.sv =====
// Top level of the audio error concealment core.
// Depends on aec_pkg, aec_if, aec_mono_decide and aec_counters.
//
//   port    dir  role    carries
//   in_i    in   sink    operation, left/right sample and bad flag
//   out_o   out  source  corrected pair, flags, three running totals
//
// One item per cycle while in_i.ready is high; a result leaves one item after its pair, on the next item.
// The decision runs from the held pair and the arriving item into the result register.
// Reset clears the holding flag and prior pair, the result valid and the totals.
// in_i.ready drops only while an unread result waits and out_o.ready is low.
module audio_error_concealment_core import aec_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int COUNT_BITS  = COUNT_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  aec_in_if.sink    in_i,
  aec_out_if.source out_o
);

  logic signed [SAMPLE_BITS-1:0] held_l_val_q, held_r_val_q;
  logic                          held_l_bad_q, held_r_bad_q;
  logic signed [SAMPLE_BITS-1:0] prior_l_val_q, prior_r_val_q;
  logic                          prior_l_bad_q, prior_r_bad_q;
  logic                          holding_q;
  logic                          out_valid_q, out_valid_d;
  logic signed [SAMPLE_BITS-1:0] out_l_val_q, out_r_val_q;
  mono_class_e                   out_l_cls_q, out_r_cls_q;

  logic                          accept, is_flush, produce;
  logic signed [SAMPLE_BITS-1:0] fol_l_val, fol_r_val;
  logic                          fol_l_bad, fol_r_bad;
  logic signed [SAMPLE_BITS-1:0] dec_l_val, dec_r_val;
  mono_class_e                   dec_l_cls, dec_r_cls;
  aec_tally_t                    tally;

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;
  assign is_flush   = in_i.operation == OP_FLUSH;
  assign produce    = accept && holding_q;

  assign fol_l_val = is_flush ? '0 : in_i.left_sample;
  assign fol_r_val = is_flush ? '0 : in_i.right_sample;
  assign fol_l_bad = is_flush || in_i.left_bad;
  assign fol_r_bad = is_flush || in_i.right_bad;

  aec_mono_decide #(.SAMPLE_BITS(SAMPLE_BITS)) u_left (
    .pre_val_i (prior_l_val_q),
    .pre_bad_i (prior_l_bad_q),
    .cur_val_i (held_l_val_q),
    .cur_bad_i (held_l_bad_q),
    .fol_val_i (fol_l_val),
    .fol_bad_i (fol_l_bad),
    .val_o     (dec_l_val),
    .cls_o     (dec_l_cls)
  );

  aec_mono_decide #(.SAMPLE_BITS(SAMPLE_BITS)) u_right (
    .pre_val_i (prior_r_val_q),
    .pre_bad_i (prior_r_bad_q),
    .cur_val_i (held_r_val_q),
    .cur_bad_i (held_r_bad_q),
    .fol_val_i (fol_r_val),
    .fol_bad_i (fol_r_bad),
    .val_o     (dec_r_val),
    .cls_o     (dec_r_cls)
  );

  assign tally = '{en: produce, left_cls: dec_l_cls, right_cls: dec_r_cls};

  aec_counters #(.COUNT_BITS(COUNT_BITS)) u_counters (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .tally_i       (tally),
    .valid_cnt_o   (out_o.valid_total),
    .conceal_cnt_o (out_o.concealed_total),
    .silence_cnt_o (out_o.silenced_total)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (produce) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      holding_q     <= 1'b0;
      prior_l_val_q <= '0;
      prior_r_val_q <= '0;
      prior_l_bad_q <= 1'b1;
      prior_r_bad_q <= 1'b1;
      out_valid_q   <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (accept && is_flush && holding_q) begin
        holding_q     <= 1'b0;
        prior_l_val_q <= '0;
        prior_r_val_q <= '0;
        prior_l_bad_q <= 1'b1;
        prior_r_bad_q <= 1'b1;
      end else if (accept && !is_flush) begin
        holding_q <= 1'b1;
        if (holding_q) begin
          prior_l_val_q <= held_l_val_q;
          prior_r_val_q <= held_r_val_q;
          prior_l_bad_q <= held_l_bad_q;
          prior_r_bad_q <= held_r_bad_q;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && !is_flush) begin
      held_l_val_q <= in_i.left_sample;
      held_r_val_q <= in_i.right_sample;
      held_l_bad_q <= in_i.left_bad;
      held_r_bad_q <= in_i.right_bad;
    end
    if (produce) begin
      out_l_val_q <= dec_l_val;
      out_r_val_q <= dec_r_val;
      out_l_cls_q <= dec_l_cls;
      out_r_cls_q <= dec_r_cls;
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.left_out        = out_l_val_q;
  assign out_o.right_out       = out_r_val_q;
  assign out_o.left_still_bad  = out_l_cls_q == CLS_SILENCE;
  assign out_o.left_concealed  = out_l_cls_q == CLS_CONCEAL;
  assign out_o.right_still_bad = out_r_cls_q == CLS_SILENCE;
  assign out_o.right_concealed = out_r_cls_q == CLS_CONCEAL;

endmodule

// ===== src/aec_checker.sv =====
// Port-level checks of the concealment core, bound to the top level.
// Depends on aec_pkg and audio_error_concealment_core_assert.svh.
`include "audio_error_concealment_core_assert.svh"

module aec_checker import aec_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int COUNT_BITS  = COUNT_BITS_DEF
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_i,
  input logic                          out_valid_i,
  input logic                          out_ready_i,
  input logic signed [SAMPLE_BITS-1:0] left_out_i,
  input logic                          left_still_bad_i,
  input logic                          left_concealed_i,
  input logic                          right_still_bad_i,
  input logic                          right_concealed_i,
  input logic [COUNT_BITS-1:0]         silenced_total_i
);

  `AEC_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i)

  `AEC_ASSERT_NEVER(a_flags_excl, clk_i, rst_ni, out_valid_i && ((left_still_bad_i && left_concealed_i) || (right_still_bad_i && right_concealed_i)))

  `AEC_ASSERT_IMPLY(a_mute_zero, clk_i, rst_ni, out_valid_i && left_still_bad_i, left_out_i == '0)

  `AEC_ASSERT_IMPLY(a_out_cause, clk_i, rst_ni, $rose(out_valid_i), $past(in_valid_i && in_ready_i))

  `AEC_ASSERT_IMPLY(a_total_cause, clk_i, rst_ni, silenced_total_i != $past(silenced_total_i), $past(in_valid_i && in_ready_i))

endmodule

bind audio_error_concealment_core aec_checker #(
  .SAMPLE_BITS (SAMPLE_BITS),
  .COUNT_BITS  (COUNT_BITS)
) u_aec_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (in_i.valid),
  .in_ready_i        (in_i.ready),
  .out_valid_i       (out_o.valid),
  .out_ready_i       (out_o.ready),
  .left_out_i        (out_o.left_out),
  .left_still_bad_i  (out_o.left_still_bad),
  .left_concealed_i  (out_o.left_concealed),
  .right_still_bad_i (out_o.right_still_bad),
  .right_concealed_i (out_o.right_concealed),
  .silenced_total_i  (out_o.silenced_total)
);
